// ----- design/wfd_pkg.sv -----
// Package for the worst-fit-decreasing packer.
// Holds field widths, reset values and register addresses; no dependencies.
package wfd_pkg;
    localparam int SizeW  = 8;
    localparam int IdW    = 6;
    localparam int CountW = 7;
    localparam int InitW  = 6;
    localparam logic [SizeW-1:0] CapReset  = 8'd10;
    localparam logic [InitW-1:0] InitReset = 6'd1;
    localparam logic [0:0] RegCapacity = 1'b0;
    localparam logic [0:0] RegInitBoxes = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_SORT = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;
endpackage

// ----- design/worst_fit_decreasing_packer_top.sv -----
// Top level of the worst-fit-decreasing packer.
// Depends on wfd_pkg, wfd_sort_cell, wfd_ram.
//
// Usage: package sizes arrive on the s_ channel, one per request. Each goes
// into a chain of sort cells that keeps them in descending order as they
// arrive (a package is taken at once while loading). A request with
// s_last_package set starts packing: the block stops taking requests, and
// for every stored package, largest first, scans the box-room RAM for the
// roomiest open box (lowest id on ties), places the package there or opens
// a new box, and offers one result on the m_ channel.
// Per package the scan reads each open box from the RAM, one read a cycle
// (the read is registered), and compares each room as it returns; the last
// scan cycle also writes the placement. The result then waits in the output
// handshake until taken. A package that fits nowhere is flagged m_oversize.
// The initial boxes are first filled with the capacity, one per cycle.
// A package beyond MAX_PACKAGES is dropped; a last one still starts packing.
// Reset (aresetn low, synchronous) empties the chain, clears the counters
// and loads the register reset values. A stalled m_ receiver holds the
// result in the output register; the scan of the next package waits.
// Registers: 0x0 box_capacity, 0x4 initial_boxes.
module worst_fit_decreasing_packer_top #(
    parameter int MAX_PACKAGES = 32,
    parameter int MAX_BOXES    = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wfd_pkg::SizeW-1:0]  s_package_size,
    input  logic                       s_last_package,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wfd_pkg::SizeW-1:0]  m_placed_size,
    output logic [wfd_pkg::IdW-1:0]    m_box_id,
    output logic [wfd_pkg::SizeW-1:0]  m_room_after,
    output logic                       m_oversize,
    output logic [wfd_pkg::CountW-1:0] m_box_count,
    output logic                       m_last_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import wfd_pkg::*;
    localparam int PW = $clog2(MAX_PACKAGES + 1);
    localparam int BW = $clog2(MAX_BOXES);
    localparam int UW = $clog2(MAX_BOXES + 1);
    localparam logic [UW-1:0] BoxMax = UW'(MAX_BOXES);
    localparam logic [PW-1:0] PkgMax = PW'(MAX_PACKAGES);

    // configuration
    logic [SizeW-1:0] cap_reg;
    logic [InitW-1:0] init_reg;
    logic             wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CapReset;
            init_reg <= InitReset;
        end else if (wr && paddr[2] == RegInitBoxes && paddr[1:0] == 2'b00) begin
            init_reg <= pwdata[InitW-1:0];
        end else if (wr && paddr[2] == RegCapacity && paddr[1:0] == 2'b00) begin
            cap_reg <= pwdata[SizeW-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == RegInitBoxes) begin
            prdata[InitW-1:0] = init_reg;
        end else begin
            prdata[SizeW-1:0] = cap_reg;
        end
    end

    state_t state_reg, state_next;
    logic [PW-1:0] count_reg;     // packages held in the chain
    logic [PW-1:0] left_reg;      // packages still to place
    logic [UW-1:0] used_reg;      // boxes open
    logic [UW-1:0] fill_reg;      // fill pointer / scan read pointer
    logic [UW-1:0] rcv_reg;       // index of data arriving from RAM
    logic          rvalid_reg;
    logic [SizeW-1:0] best_room_reg;
    logic [BW-1:0]    best_id_reg;
    logic             acc, pop, clr, ins;
    logic [SizeW-1:0] head;

    assign s_ready = (state_reg == ST_LOAD);
    assign acc = s_valid && s_ready;
    assign clr = !aresetn;
    assign ins = acc && count_reg < PkgMax;

    // sort chain: the new size is broadcast, each cell looks only at its
    // upper neighbor to decide whether to shift down
    logic [SizeW-1:0] od [MAX_PACKAGES+1];
    logic             ov [MAX_PACKAGES+1];
    logic [SizeW-1:0] pd [MAX_PACKAGES];
    logic             pv [MAX_PACKAGES];
    logic             pt [MAX_PACKAGES];
    logic             tk [MAX_PACKAGES];
    assign od[MAX_PACKAGES] = '0;
    assign ov[MAX_PACKAGES] = 1'b0;
    for (genvar g = 0; g < MAX_PACKAGES; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign pd[g] = '0;
            assign pv[g] = 1'b0;
            assign pt[g] = 1'b0;
        end else begin : g_rest
            assign pd[g] = od[g-1];
            assign pv[g] = ov[g-1];
            assign pt[g] = tk[g-1];
        end
        wfd_sort_cell u_cell (
            .aclk(aclk), .clr(clr), .shift_in(acc), .new_data(s_package_size),
            .new_valid(ins), .prev_take(pt[g]), .prev_data(pd[g]),
            .prev_valid(pv[g]), .pop(pop), .next_data(od[g+1]),
            .next_valid(ov[g+1]), .data_out(od[g]), .valid_out(ov[g]),
            .take_out(tk[g])
        );
    end
    assign head = od[0];

    // box rooms
    logic             we;
    logic [BW-1:0]    waddr;
    logic [SizeW-1:0] wdata, rdata;
    wfd_ram #(.Width(SizeW), .Depth(MAX_BOXES)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(fill_reg[BW-1:0]), .rdata(rdata)
    );

    logic [UW-1:0] init_lim;
    always_comb begin
        if (init_reg == '0) begin
            init_lim = UW'(1);
        end else if (int'(init_reg) > MAX_BOXES) begin
            init_lim = BoxMax;
        end else begin
            init_lim = UW'(init_reg);
        end
    end

    // placement decision (valid when scan ends)
    logic             fits, can_open;
    logic [BW-1:0]    p_id;
    logic [SizeW-1:0] p_room;
    logic             p_over;
    logic [UW-1:0]    p_used;
    assign fits     = best_room_reg >= head;
    assign can_open = used_reg < BoxMax;
    always_comb begin
        p_over = 1'b0;
        p_used = used_reg;
        if (fits) begin
            p_id   = best_id_reg;
            p_room = best_room_reg - head;
        end else if (can_open) begin
            p_id   = used_reg[BW-1:0];
            p_used = used_reg + UW'(1);
            p_over = head > cap_reg;
            p_room = p_over ? '0 : cap_reg - head;
        end else begin
            p_id   = best_id_reg;
            p_room = '0;
            p_over = 1'b1;
        end
    end

    logic scan_done;
    assign scan_done = (state_reg == ST_SCAN) && !rvalid_reg && fill_reg >= used_reg;
    assign pop = (state_reg == ST_EMIT) && m_valid && m_ready;

    always_comb begin
        we    = 1'b0;
        waddr = fill_reg[BW-1:0];
        wdata = cap_reg;
        if (state_reg == ST_SORT && fill_reg < init_lim) begin
            we = 1'b1;
        end else if (scan_done) begin
            we    = 1'b1;
            waddr = p_id;
            wdata = p_room;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (acc && s_last_package) state_next = ST_SORT;
            ST_SORT: begin
                if (fill_reg >= init_lim) begin
                    state_next = (left_reg == '0) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_SCAN: if (scan_done) state_next = ST_EMIT;
            ST_EMIT: begin
                if (pop) state_next = (left_reg == PW'(1)) ? ST_LOAD : ST_SCAN;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            left_reg   <= '0;
            used_reg   <= '0;
            fill_reg   <= '0;
            rcv_reg    <= '0;
            rvalid_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_LOAD: begin
                    fill_reg <= '0;
                    if (acc) begin
                        if (s_last_package) begin
                            left_reg <= (count_reg < PkgMax) ? count_reg + PW'(1)
                                                            : count_reg;
                            count_reg <= '0;
                        end else if (count_reg < PkgMax) begin
                            count_reg <= count_reg + PW'(1);
                        end
                    end
                end
                ST_SORT: begin
                    if (fill_reg < init_lim) begin
                        fill_reg <= fill_reg + UW'(1);
                    end else begin
                        used_reg   <= init_lim;
                        fill_reg   <= '0;
                        rvalid_reg <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // issue reads 0..used-1; compare each as it returns
                    rvalid_reg <= fill_reg < used_reg;
                    rcv_reg    <= fill_reg;
                    if (fill_reg < used_reg) fill_reg <= fill_reg + UW'(1);
                    if (rvalid_reg) begin
                        if (rcv_reg == '0 || rdata > best_room_reg) begin
                            best_room_reg <= rdata;
                            best_id_reg   <= rcv_reg[BW-1:0];
                        end
                    end
                    if (scan_done) begin
                        m_valid       <= 1'b1;
                        m_placed_size <= head;
                        m_box_id      <= IdW'(p_id);
                        m_room_after  <= p_room;
                        m_oversize    <= p_over;
                        m_box_count   <= CountW'(p_used);
                        m_last_result <= left_reg == PW'(1);
                        used_reg      <= p_used;
                    end
                end
                ST_EMIT: begin
                    if (pop) begin
                        m_valid    <= 1'b0;
                        left_reg   <= left_reg - PW'(1);
                        fill_reg   <= '0;
                        rvalid_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- design/wfd_sort_cell.sv -----
// One cell of the insertion-sort chain: holds one size, shifts down when a
// larger one is inserted above it and up on a pop. Depends on wfd_pkg.
module wfd_sort_cell (
    input  logic                      aclk,
    input  logic                      clr,
    input  logic                      shift_in,
    input  logic [wfd_pkg::SizeW-1:0] new_data,
    input  logic                      new_valid,
    input  logic                      prev_take,
    input  logic [wfd_pkg::SizeW-1:0] prev_data,
    input  logic                      prev_valid,
    input  logic                      pop,
    input  logic [wfd_pkg::SizeW-1:0] next_data,
    input  logic                      next_valid,
    output logic [wfd_pkg::SizeW-1:0] data_out,
    output logic                      valid_out,
    output logic                      take_out
);
    import wfd_pkg::*;
    logic [SizeW-1:0] data_reg;
    logic             valid_reg;

    // new size belongs here or above; the chain stays descending, so once
    // one cell takes, every cell below it takes too
    assign take_out  = new_valid && (!valid_reg || new_data > data_reg);
    assign data_out  = data_reg;
    assign valid_out = valid_reg;

    always_ff @(posedge aclk) begin
        if (clr) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            data_reg  <= next_data;
            valid_reg <= next_valid;
        end else if (shift_in && prev_take) begin
            data_reg  <= prev_data;
            valid_reg <= prev_valid;
        end else if (shift_in && take_out) begin
            data_reg  <= new_data;
            valid_reg <= 1'b1;
        end
    end
endmodule

// ----- design/wfd_ram.sv -----
// Generic single-port-write RAM with registered read; no dependencies.
module wfd_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/wfd_checker.sv -----
// Port-level checker for the packer, bound to the top level.
// Depends on worst_fit_decreasing_packer_top.
module wfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_room_after,
    input logic       m_oversize,
    input logic [6:0] m_box_count
);
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_over_room: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_oversize |-> m_room_after == 8'd0) else $error("oversize room");
    a_count_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_box_count != 7'd0) else $error("zero box count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_room_after))
        else $error("result dropped");
endmodule

bind worst_fit_decreasing_packer_top wfd_checker u_wfd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_room_after(m_room_after),
    .m_oversize(m_oversize), .m_box_count(m_box_count)
);
